// ----- src/ifhg_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the ipv4 fragment header generator
// no dependencies
package ifhg_pkg;

    localparam int REG_ADDR_W = 4;
    localparam logic [1:0] REG_SOURCE_ADDR  = 2'd0;
    localparam logic [1:0] REG_FRAG_PAYLOAD = 2'd1;
    localparam logic [1:0] REG_DF_LIMIT     = 2'd2;

    localparam logic [12:0] FRAG_RESET     = 13'd1480;
    localparam logic [15:0] DF_LIMIT_RESET = 16'd576;
    localparam logic [12:0] MIN_FRAG       = 13'd1024;
    localparam logic [12:0] FRAG_MASK      = 13'h1FF8;
    localparam logic [15:0] HDR_BYTES      = 16'd20;
    localparam logic [15:0] VER_IHL_TOS    = 16'h4500;
    localparam logic [7:0]  TTL_VALUE      = 8'hFF;

    localparam int NUM_WORDS = 9;
    localparam int STEP_W    = $clog2(NUM_WORDS);

    typedef struct packed {
        logic [31:0] source_addr;
        logic [12:0] fragment_payload;
        logic [15:0] dont_fragment_limit;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic add;
    } csum_ctrl_t;

    function automatic logic [12:0] eff_frag(input logic [12:0] raw);
        logic [12:0] f;
        f = raw & FRAG_MASK;
        if (f < MIN_FRAG)
        begin
            f = MIN_FRAG;
        end
        return f;
    endfunction

endpackage

// ----- src/ifhg_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result items
// depends on nothing
interface ifhg_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_length;
    logic [15:0] already_sent;
    logic [15:0] ident;
    logic [7:0]  protocol;
    logic [31:0] dest_addr;

    modport source (output valid, output payload_length, output already_sent,
                    output ident, output protocol, output dest_addr, input ready);
    modport sink (input valid, input payload_length, input already_sent,
                  input ident, input protocol, input dest_addr, output ready);
endinterface

interface ifhg_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] slice_start;
    logic [12:0] slice_len;
    logic [15:0] total_length;
    logic [15:0] flags_offset;
    logic [15:0] header_checksum;
    logic [15:0] ident_out;
    logic [7:0]  protocol_out;
    logic [31:0] dest_out;
    logic        last;
    logic        error;

    modport source (output valid, output slice_start, output slice_len,
                    output total_length, output flags_offset, output header_checksum,
                    output ident_out, output protocol_out, output dest_out,
                    output last, output error, input ready);
    modport sink (input valid, input slice_start, input slice_len,
                  input total_length, input flags_offset, input header_checksum,
                  input ident_out, input protocol_out, input dest_out,
                  input last, input error, output ready);
endinterface

// ----- src/ifhg_cfg_regs.sv -----
`timescale 1ns / 1ps
// apb configuration registers: source address, fragment size, df limit
// depends on ifhg_pkg
module ifhg_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ifhg_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output ifhg_pkg::cfg_t                    cfg
);
    import ifhg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SOURCE_ADDR:  cfg_next.source_addr = pwdata;
                REG_FRAG_PAYLOAD: cfg_next.fragment_payload = pwdata[12:0];
                REG_DF_LIMIT:     cfg_next.dont_fragment_limit = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SOURCE_ADDR:  prdata = cfg_reg.source_addr;
            REG_FRAG_PAYLOAD: prdata = {19'd0, cfg_reg.fragment_payload};
            REG_DF_LIMIT:     prdata = {16'd0, cfg_reg.dont_fragment_limit};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_addr         <= 32'd0;
            cfg_reg.fragment_payload    <= FRAG_RESET;
            cfg_reg.dont_fragment_limit <= DF_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/ifhg_csum_unit.sv -----
`timescale 1ns / 1ps
// shared one's complement accumulator, one 16-bit word per cycle
// depends on ifhg_pkg
module ifhg_csum_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ifhg_pkg::csum_ctrl_t  ctrl,
    input  logic [15:0]           word,
    output logic [15:0]           checksum
);
    import ifhg_pkg::*;

    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [16:0] sum;

    // end-around carry keeps the sum in 16 bits
    assign sum = {1'b0, acc_reg} + {1'b0, word};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = 16'd0;
        end
        else if (ctrl.add)
        begin
            acc_next = sum[15:0] + {15'd0, sum[16]};
        end
    end

    assign checksum = ~acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 16'd0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- src/ipv4_fragment_header_gen.sv -----
`timescale 1ns / 1ps
// Splits one IPv4 send request into fragments and emits one result item per
// fragment with its slice, total length, flags/offset word and header checksum.
// The checksum comes from one shared 16-bit adder stepping through the nine
// header words, so each fragment takes a setup step, one add per header word
// and a load of the output register, which waits while the result side stalls.
// An invalid request goes to an error state and gives a single error item once
// the output register is free. The input is not ready while a request is in
// progress; a finished item waits in the output register.
// depends on ifhg_pkg, ifhg_if, ifhg_cfg_regs, ifhg_csum_unit
module ipv4_fragment_header_gen (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ifhg_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    ifhg_req_if.sink                          req,
    ifhg_res_if.source                        res
);
    import ifhg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_WORDS - 1);

    cfg_t        cfg;
    csum_ctrl_t  csum_ctrl;
    logic [15:0] csum_word;
    logic [15:0] checksum;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       sent_reg, sent_next;
    logic [15:0]       left_reg, left_next;
    logic [12:0]       frag_reg, frag_next;
    logic [15:0]       ident_reg, ident_next;
    logic [7:0]        proto_reg, proto_next;
    logic [31:0]       dst_reg, dst_next;
    logic [12:0]       seg_reg, seg_next;
    logic [15:0]       total_reg, total_next;
    logic [15:0]       fo_reg, fo_next;
    logic              last_reg, last_next;

    logic              out_valid_reg, out_valid_next;
    logic [15:0]       o_start_reg, o_start_next;
    logic [12:0]       o_len_reg, o_len_next;
    logic [15:0]       o_total_reg, o_total_next;
    logic [15:0]       o_fo_reg, o_fo_next;
    logic [15:0]       o_csum_reg, o_csum_next;
    logic [15:0]       o_ident_reg, o_ident_next;
    logic [7:0]        o_proto_reg, o_proto_next;
    logic [31:0]       o_dst_reg, o_dst_next;
    logic              o_last_reg, o_last_next;
    logic              o_err_reg, o_err_next;

    logic [15:0] words [NUM_WORDS];
    logic        out_free;
    logic        req_bad;
    logic        frag_last;
    logic [12:0] frag_seg;
    logic [15:0] frag_total;
    logic [12:0] frag_off;
    logic        frag_df;

    ifhg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifhg_csum_unit u_csum (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (csum_ctrl),
        .word     (csum_word),
        .checksum (checksum)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || res.ready;
    assign req_bad   = (req.already_sent >= req.payload_length)
                       || (req.already_sent[2:0] != 3'd0);

    // per fragment fields
    assign frag_last  = left_reg <= {3'd0, frag_reg};
    assign frag_seg   = frag_last ? left_reg[12:0] : frag_reg;
    assign frag_total = {3'd0, frag_seg} + HDR_BYTES;
    assign frag_off   = sent_reg[15:3];
    assign frag_df    = (frag_total <= cfg.dont_fragment_limit) && (frag_off == 13'd0);

    // header words in checksum order
    assign words[0] = VER_IHL_TOS;
    assign words[1] = total_reg;
    assign words[2] = ident_reg;
    assign words[3] = fo_reg;
    assign words[4] = {TTL_VALUE, proto_reg};
    assign words[5] = cfg.source_addr[31:16];
    assign words[6] = cfg.source_addr[15:0];
    assign words[7] = dst_reg[31:16];
    assign words[8] = dst_reg[15:0];
    assign csum_word = words[step_reg];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sent_next  = sent_reg;
        left_next  = left_reg;
        frag_next  = frag_reg;
        ident_next = ident_reg;
        proto_next = proto_reg;
        dst_next   = dst_reg;
        seg_next   = seg_reg;
        total_next = total_reg;
        fo_next    = fo_reg;
        last_next  = last_reg;
        csum_ctrl  = '0;

        out_valid_next = out_valid_reg && !res.ready;
        o_start_next   = o_start_reg;
        o_len_next     = o_len_reg;
        o_total_next   = o_total_reg;
        o_fo_next      = o_fo_reg;
        o_csum_next    = o_csum_reg;
        o_ident_next   = o_ident_reg;
        o_proto_next   = o_proto_reg;
        o_dst_next     = o_dst_reg;
        o_last_next    = o_last_reg;
        o_err_next     = o_err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    sent_next  = req.already_sent;
                    left_next  = req.payload_length - req.already_sent;
                    frag_next  = eff_frag(cfg.fragment_payload);
                    ident_next = req.ident;
                    proto_next = req.protocol;
                    dst_next   = req.dest_addr;
                    state_next = req_bad ? ST_ERR : ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                seg_next        = frag_seg;
                total_next      = frag_total;
                fo_next         = {1'b0, frag_df, !frag_last, frag_off};
                last_next       = frag_last;
                step_next       = '0;
                csum_ctrl.clear = 1'b1;
                state_next      = ST_SUM;
            end
            ST_SUM:
            begin
                csum_ctrl.add = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_start_next   = sent_reg;
                    o_len_next     = seg_reg;
                    o_total_next   = total_reg;
                    o_fo_next      = fo_reg;
                    o_csum_next    = checksum;
                    o_ident_next   = ident_reg;
                    o_proto_next   = proto_reg;
                    o_dst_next     = dst_reg;
                    o_last_next    = last_reg;
                    o_err_next     = 1'b0;
                    sent_next      = sent_reg + {3'd0, seg_reg};
                    left_next      = left_reg - {3'd0, seg_reg};
                    state_next     = last_reg ? ST_IDLE : ST_SETUP;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_start_next   = 16'd0;
                    o_len_next     = 13'd0;
                    o_total_next   = 16'd0;
                    o_fo_next      = 16'd0;
                    o_csum_next    = 16'd0;
                    o_ident_next   = 16'd0;
                    o_proto_next   = 8'd0;
                    o_dst_next     = 32'd0;
                    o_last_next    = 1'b1;
                    o_err_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sent_reg    <= sent_next;
        left_reg    <= left_next;
        frag_reg    <= frag_next;
        ident_reg   <= ident_next;
        proto_reg   <= proto_next;
        dst_reg     <= dst_next;
        seg_reg     <= seg_next;
        total_reg   <= total_next;
        fo_reg      <= fo_next;
        last_reg    <= last_next;
        o_start_reg <= o_start_next;
        o_len_reg   <= o_len_next;
        o_total_reg <= o_total_next;
        o_fo_reg    <= o_fo_next;
        o_csum_reg  <= o_csum_next;
        o_ident_reg <= o_ident_next;
        o_proto_reg <= o_proto_next;
        o_dst_reg   <= o_dst_next;
        o_last_reg  <= o_last_next;
        o_err_reg   <= o_err_next;
    end

    assign res.valid           = out_valid_reg;
    assign res.slice_start     = o_start_reg;
    assign res.slice_len       = o_len_reg;
    assign res.total_length    = o_total_reg;
    assign res.flags_offset    = o_fo_reg;
    assign res.header_checksum = o_csum_reg;
    assign res.ident_out       = o_ident_reg;
    assign res.protocol_out    = o_proto_reg;
    assign res.dest_out        = o_dst_reg;
    assign res.last            = o_last_reg;
    assign res.error           = o_err_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.error |-> res.last && res.slice_len == 13'd0)
        else $error("error item not a lone last item");

    a_mf_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.error |-> res.flags_offset[13] == !res.last)
        else $error("more fragments flag disagrees with last");

    a_total_len: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.error |-> res.total_length == {3'd0, res.slice_len} + HDR_BYTES)
        else $error("total length does not match slice length");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("checksum step counter out of range");

endmodule
